/* hw/rtl/sfc_pkg.sv */
package sfc_pkg;

    // Widths fixed by the item formats.
    localparam int MAG_W     = 16;
    localparam int SUM_W     = 22;
    localparam int COUNT_W   = 7;
    localparam int BIN_IDX_W = 6;
    localparam int COLOR_W   = 8;
    localparam int COL_W     = 5;

    // Highest gradient index.
    localparam logic [7:0] GRAD_TOP = 8'd200;

    // Frames that may be loaded or waiting in the two store banks.
    localparam logic [1:0] FRAMES_IN_FLIGHT = 2'd2;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             last_bin;
    } t_in_item;

    typedef struct packed {
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
        logic [BIN_IDX_W-1:0] bin_index;
        logic [COL_W-1:0]     column;
        logic                 final_res;
    } t_out_item;

    // Store write from the loader to the bin memory.
    typedef struct packed {
        logic                 en;
        logic                 bank;
        logic [BIN_IDX_W-1:0] index;
        logic [MAG_W-1:0]     data;
    } t_bin_write;

    // One finished frame handed from the loader to the colorizer.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
        logic [MAG_W-1:0]   maximum;
        logic               bank;
    } t_frame_desc;

    // Gradient knots: positions and RGB colors.
    localparam logic [5:0][7:0] KNOT_POS = {
        8'd200, 8'd145, 8'd110, 8'd70, 8'd30, 8'd0
    };
    localparam logic [5:0][23:0] KNOT_RGB = {
        24'hff3c1e, 24'he0e02c, 24'h5ab464, 24'h506499, 24'h0e1116, 24'h000000
    };

    typedef logic [200:0][23:0] t_grad;

    // Linear interpolation between knots, evaluated once at elaboration.
    function automatic t_grad build_gradient();
        t_grad g;
        int    i0;
        int    i1;
        int    c0;
        int    c1;
        int    num;
        int    c;
        g = '0;
        for (int seg = 0; seg < 5; seg++) begin
            i0 = int'(KNOT_POS[seg]);
            i1 = int'(KNOT_POS[seg + 1]);
            for (int k = i0; k < i1; k++) begin
                for (int ch = 0; ch < 3; ch++) begin
                    c0  = int'(KNOT_RGB[seg][ch*8 +: 8]);
                    c1  = int'(KNOT_RGB[seg + 1][ch*8 +: 8]);
                    num = c0 * (i1 - k) + c1 * (k - i0);
                    // Shift-and-subtract by the segment span; the quotient fits 8 bits.
                    c   = 0;
                    for (int b = 7; b >= 0; b--) begin
                        if (num >= ((i1 - i0) << b)) begin
                            num = num - ((i1 - i0) << b);
                            c   = c + (1 << b);
                        end
                    end
                    g[k][ch*8 +: 8] = 8'(c);
                end
            end
        end
        g[200] = KNOT_RGB[5];
        return g;
    endfunction

    localparam t_grad GRADIENT_ROM = build_gradient();

endpackage

/* hw/rtl/sfc_front.sv */
module sfc_front import sfc_pkg::*; #(
    parameter int MAX_BINS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    input  logic        i_frame_done,
    output t_bin_write  o_bin_write,
    output logic        o_push,
    output t_frame_desc o_push_desc
);

    localparam int CNTW = $clog2(MAX_BINS + 1);

    logic [CNTW-1:0]  r_count, n_count;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [MAG_W-1:0] r_max, n_max;
    logic             r_bank, n_bank;
    logic [1:0]       r_inflight, n_inflight;

    logic             accept;
    logic             frame_end;
    logic [SUM_W-1:0] sum_add;
    logic [MAG_W-1:0] max_upd;

    // Both banks hold frames that the colorizer has not finished.
    assign o_in_stall = (r_inflight == FRAMES_IN_FLIGHT);
    assign accept     = i_in_valid && !o_in_stall;

    // Running sum and maximum including the current request.
    assign sum_add = r_sum + SUM_W'(i_in_item.magnitude);
    assign max_upd = (i_in_item.magnitude > r_max) ? i_in_item.magnitude : r_max;

    // A frame ends on the flag or when the bank is full.
    assign frame_end = i_in_item.last_bin || (r_count == CNTW'(MAX_BINS - 1));

    always_comb begin
        o_bin_write.en    = accept;
        o_bin_write.bank  = r_bank;
        o_bin_write.index = BIN_IDX_W'(r_count);
        o_bin_write.data  = i_in_item.magnitude;

        o_push              = accept && frame_end;
        o_push_desc.count   = COUNT_W'(r_count) + COUNT_W'(1);
        o_push_desc.sum     = sum_add;
        o_push_desc.maximum = max_upd;
        o_push_desc.bank    = r_bank;
    end

    // Frame accumulation and bank tracking.
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_max   = r_max;
        n_bank  = r_bank;
        if (accept) begin
            if (frame_end) begin
                n_count = '0;
                n_sum   = '0;
                n_max   = '0;
                n_bank  = !r_bank;
            end else begin
                n_count = r_count + CNTW'(1);
                n_sum   = sum_add;
                n_max   = max_upd;
            end
        end
        n_inflight = r_inflight + {1'b0, o_push} - {1'b0, i_frame_done};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_sum      <= '0;
            r_max      <= '0;
            r_bank     <= 1'b0;
            r_inflight <= '0;
        end else begin
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_max      <= n_max;
            r_bank     <= n_bank;
            r_inflight <= n_inflight;
        end
    end

endmodule

/* hw/rtl/sfc_queue.sv */
module sfc_queue import sfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_frame_desc i_push_desc,
    input  logic        i_pop,
    output t_frame_desc o_pop_desc,
    output logic        o_empty
);

    t_frame_desc r_slot [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_fill;

    assign o_pop_desc = r_slot[r_rd_ptr];
    assign o_empty    = (r_fill == 2'd0);

    // Two-entry descriptor queue; the loader never pushes when both are used.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_fill <= r_fill + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

/* hw/rtl/sfc_back.sv */
module sfc_back import sfc_pkg::*; #(
    parameter int MAX_BINS      = 64,
    parameter int FRAME_COLUMNS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_bin_write  i_bin_write,
    input  t_frame_desc i_desc,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_frame_done,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item
);

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CW = $clog2(FRAME_COLUMNS);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_MEAN = 10'b0000000010,
        ST_PEAK = 10'b0000000100,
        ST_PSQ  = 10'b0000001000,
        ST_DEN  = 10'b0000010000,
        ST_READ = 10'b0000100000,
        ST_MSQ  = 10'b0001000000,
        ST_NUM  = 10'b0010000000,
        ST_DIV  = 10'b0100000000,
        ST_EMIT = 10'b1000000000
    } t_state;

    t_state             r_state;
    logic [MAG_W-1:0]   r_peak;
    logic [CW-1:0]      r_col;
    logic               r_out_valid;
    t_out_item          r_out;

    // Bin memory, two banks.
    logic [MAG_W-1:0]   r_bins [2**(AW+1)];
    logic [MAG_W-1:0]   r_rdata;

    // Frame setup datapath.
    logic [COUNT_W-1:0] r_n;
    logic               r_bank;
    logic [MAG_W-1:0]   r_max;
    logic [COUNT_W:0]   r_div;
    logic [23:0]        r_dvd;
    logic [COUNT_W:0]   r_rem;
    logic [23:0]        r_quo;
    logic [4:0]         r_step;
    logic [19:0]        r_lim11;
    logic [31:0]        r_psq;
    logic [38:0]        r_den;

    // Per-bin datapath.
    logic [AW-1:0]      r_k;
    logic [31:0]        r_msq;
    logic               r_big;
    logic [46:0]        r_num;
    logic [46:0]        r_dsh;
    logic [7:0]         r_idx;

    logic [COUNT_W+1:0] mean_trial;
    logic               mean_ge;
    logic [MAG_W-1:0]   mean_sat;
    logic [MAG_W-1:0]   half_peak;
    logic [MAG_W-1:0]   pk_a;
    logic [MAG_W-1:0]   pk_b;
    logic [MAG_W-1:0]   new_peak;
    logic               div_ge;
    logic [7:0]         grad_idx;
    logic [23:0]        rgb;
    logic               last_k;
    logic               can_load;
    logic               load;
    logic               rd_en;
    logic [CW+4:0]      col_ext;
    t_out_item          item;

    // Mean divide step: floor(3 * sum / (2 * n)), one quotient bit a cycle.
    assign mean_trial = {r_rem, r_dvd[23]};
    assign mean_ge    = (mean_trial >= {1'b0, r_div});
    assign mean_sat   = (|r_quo[23:16]) ? {MAG_W{1'b1}} : r_quo[MAG_W-1:0];

    // New peak: largest of half peak, frame maximum and mean term, at least one.
    assign half_peak = {1'b0, r_peak[MAG_W-1:1]};
    assign pk_a      = (r_max > half_peak) ? r_max : half_peak;
    assign pk_b      = (mean_sat > pk_a) ? mean_sat : pk_a;
    assign new_peak  = (pk_b == '0) ? MAG_W'(1) : pk_b;

    // Index divide step: 20000 * m^2 over 121 * peak^2, eight quotient bits.
    assign div_ge = (r_num >= r_dsh);

    // Bins at or above 1.1 times the peak take the top color.
    assign grad_idx = (r_big || (r_idx > GRAD_TOP)) ? GRAD_TOP : r_idx;
    assign rgb      = GRADIENT_ROM[grad_idx];

    assign last_k   = ((COUNT_W'(r_k) + COUNT_W'(1)) == r_n);
    assign can_load = !r_out_valid || !i_out_stall;
    assign load     = (r_state == ST_EMIT) && can_load;
    assign rd_en    = (r_state == ST_READ);

    assign o_pop        = (r_state == ST_IDLE) && !i_empty;
    assign o_frame_done = load && last_k;
    assign o_out_valid  = r_out_valid;
    assign o_out_item   = r_out;

    assign col_ext = {5'd0, r_col};

    always_comb begin
        item.red       = rgb[23:16];
        item.green     = rgb[15:8];
        item.blue      = rgb[7:0];
        item.bin_index = BIN_IDX_W'(r_k);
        item.column    = col_ext[COL_W-1:0];
        item.final_res = last_k;
    end

    // Bin memory: loader writes one bank while this side reads the other.
    always_ff @(posedge i_clk) begin
        if (i_bin_write.en) begin
            r_bins[{i_bin_write.bank, i_bin_write.index[AW-1:0]}] <= i_bin_write.data;
        end
        if (rd_en) begin
            r_rdata <= r_bins[{r_bank, r_k}];
        end
    end

    // Sequencer, peak, column and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_peak      <= {MAG_W{1'b1}};
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    if (r_step == 5'd0) begin
                        r_state <= ST_PEAK;
                    end
                end
                ST_PEAK: begin
                    r_peak  <= new_peak;
                    r_state <= ST_PSQ;
                end
                ST_PSQ:  r_state <= ST_DEN;
                ST_DEN:  r_state <= ST_READ;
                ST_READ: r_state <= ST_MSQ;
                ST_MSQ:  r_state <= ST_NUM;
                ST_NUM:  r_state <= ST_DIV;
                ST_DIV: begin
                    if (r_step == 5'd0) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (can_load) begin
                        if (last_k) begin
                            r_state <= ST_IDLE;
                            if (r_col == CW'(FRAME_COLUMNS - 1)) begin
                                r_col <= '0;
                            end else begin
                                r_col <= r_col + CW'(1);
                            end
                        end else begin
                            r_state <= ST_READ;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Arithmetic datapath, stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    r_n    <= i_desc.count;
                    r_bank <= i_desc.bank;
                    r_max  <= i_desc.maximum;
                    r_div  <= {i_desc.count, 1'b0};
                    r_dvd  <= {2'b00, i_desc.sum} + {1'b0, i_desc.sum, 1'b0};
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_step <= 5'd23;
                    r_k    <= '0;
                end
            end
            ST_MEAN: begin
                if (mean_ge) begin
                    r_rem <= mean_trial[COUNT_W:0] - r_div;
                end else begin
                    r_rem <= mean_trial[COUNT_W:0];
                end
                r_quo  <= {r_quo[22:0], mean_ge};
                r_dvd  <= {r_dvd[22:0], 1'b0};
                r_step <= r_step - 5'd1;
            end
            ST_PEAK: begin
                r_lim11 <= 20'(new_peak) * 20'd11;
            end
            ST_PSQ: begin
                r_psq <= 32'(r_peak) * 32'(r_peak);
            end
            ST_DEN: begin
                r_den <= 39'(r_psq) * 39'd121;
            end
            ST_MSQ: begin
                r_msq <= 32'(r_rdata) * 32'(r_rdata);
                r_big <= ((20'(r_rdata) * 20'd10) >= r_lim11);
            end
            ST_NUM: begin
                r_num  <= 47'(r_msq) * 47'd20000;
                r_dsh  <= {1'b0, r_den, 7'd0};
                r_idx  <= '0;
                r_step <= 5'd7;
            end
            ST_DIV: begin
                if (div_ge) begin
                    r_num <= r_num - r_dsh;
                end
                r_idx  <= {r_idx[6:0], div_ge};
                r_dsh  <= {1'b0, r_dsh[46:1]};
                r_step <= r_step - 5'd1;
            end
            ST_EMIT: begin
                if (can_load) begin
                    r_out <= item;
                    if (!last_k) begin
                        r_k <= r_k + AW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* hw/rtl/spectrum_frame_colorizer_top.sv */
// Bins are taken one per cycle into one of two store banks; requests stall
// only while both banks hold frames that are not yet fully colored.
// Per frame the colorizer runs a setup (a 24-step mean divide, the peak update
// and the denominator) and then, per bin, a store read, the squares and an
// 8-step index divide. Reset is synchronous, active low, and clears control
// state at once; the bin store is not cleared.
module spectrum_frame_colorizer_top import sfc_pkg::*; #(
    parameter int MAX_BINS      = 64,
    parameter int FRAME_COLUMNS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_bin_write  bin_write;
    t_frame_desc push_desc;
    t_frame_desc pop_desc;
    logic        push;
    logic        pop;
    logic        empty;
    logic        frame_done;

    // Loader: stores bins and summarizes each frame.
    sfc_front #(
        .MAX_BINS(MAX_BINS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_frame_done(frame_done),
        .o_bin_write (bin_write),
        .o_push      (push),
        .o_push_desc (push_desc)
    );

    // Frame descriptors waiting for the colorizer.
    sfc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_desc(push_desc),
        .i_pop      (pop),
        .o_pop_desc (pop_desc),
        .o_empty    (empty)
    );

    // Colorizer: peak update, per-bin index and gradient lookup.
    sfc_back #(
        .MAX_BINS     (MAX_BINS),
        .FRAME_COLUMNS(FRAME_COLUMNS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bin_write (bin_write),
        .i_desc      (pop_desc),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_frame_done(frame_done),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

/* tb/spectrum_frame_colorizer_top_tb.sv */
module spectrum_frame_colorizer_top_tb;
    import sfc_pkg::*;

    localparam int MAX_BINS      = 64;
    localparam int FRAME_COLUMNS = 32;
    localparam int RANDOM_ITEMS  = 160;
    localparam int CALM_LEFT     = 40;
    localparam int IDLE_LIMIT    = 5000;
    localparam int TAIL_CYCLES   = 120;
    localparam int GRAD_LEN      = 201;

    logic      i_clk    = 1'b0;
    logic      i_rst_n  = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item  = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    spectrum_frame_colorizer_top #(
        .MAX_BINS     (MAX_BINS),
        .FRAME_COLUMNS(FRAME_COLUMNS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item)
    );

    always #1 i_clk = ~i_clk;

    // Requests waiting to be driven, and colors the block still owes us.
    t_in_item  bins_to_send[$];
    t_out_item colors_due[$];

    // Shadow of the block state.
    logic [MAG_W-1:0]   frame_bins [MAX_BINS];
    logic [MAG_W-1:0]   peak_q;
    logic [MAG_W-1:0]   max_q;
    logic [SUM_W-1:0]   sum_q;
    logic [COUNT_W-1:0] loaded_q;
    int unsigned        column_q;
    logic [23:0]        palette [GRAD_LEN];

    int error_count = 0;
    int idle_cycles = 0;
    int send_gap    = 0;
    int hold_gap    = 0;

    task automatic flag_error(string msg);
        if (error_count < 10) begin
            $display("%s", msg);
        end
        error_count++;
    endtask

    // One straight segment of the color gradient, per channel.
    task automatic ramp(int lo, int hi, logic [23:0] c_lo, logic [23:0] c_hi);
        int a;
        int b;
        for (int k = lo; k < hi; k++) begin
            for (int ch = 0; ch < 3; ch++) begin
                a = int'(c_lo[ch*8 +: 8]);
                b = int'(c_hi[ch*8 +: 8]);
                palette[k][ch*8 +: 8] = 8'((a * (hi - k) + b * (k - lo)) / (hi - lo));
            end
        end
    endtask

    // Gradient position for magnitude m against peak p, exact rational form.
    function automatic int unsigned grad_index(logic [MAG_W-1:0] m, logic [MAG_W-1:0] p);
        int unsigned     mw;
        int unsigned     pw;
        longint unsigned q;
        mw = m;
        pw = p;
        if (10 * mw >= 11 * pw) begin
            return 200;
        end
        q = (64'd20000 * mw * mw) / (64'd121 * pw * pw);
        return (q > 200) ? 200 : int'(q);
    endfunction

    // Take one bin into the shadow state; at frame end queue its colors.
    task automatic absorb_bin(t_in_item it);
        int unsigned n;
        int unsigned p;
        int unsigned mean_term;
        logic [23:0] rgb;
        t_out_item   c;
        if (loaded_q == MAX_BINS) begin
            loaded_q = '0;
        end
        frame_bins[loaded_q] = it.magnitude;
        loaded_q = loaded_q + 1'b1;
        sum_q = sum_q + it.magnitude;
        if (it.magnitude > max_q) begin
            max_q = it.magnitude;
        end
        if (it.last_bin || loaded_q == MAX_BINS) begin
            n = loaded_q;
            p = peak_q >> 1;
            if (max_q > p) begin
                p = max_q;
            end
            mean_term = (3 * sum_q) / (2 * n);
            if (mean_term > p) begin
                p = mean_term;
            end
            if (p > 65535) begin
                p = 65535;
            end
            if (p < 1) begin
                p = 1;
            end
            peak_q = p[MAG_W-1:0];
            for (int k = 0; k < n; k++) begin
                rgb = palette[grad_index(frame_bins[k], peak_q)];
                c.red       = rgb[23:16];
                c.green     = rgb[15:8];
                c.blue      = rgb[7:0];
                c.bin_index = BIN_IDX_W'(k);
                c.column    = COL_W'(column_q);
                c.final_res = (k + 1 == n);
                colors_due.push_back(c);
            end
            column_q = (column_q + 1 >= FRAME_COLUMNS) ? 0 : column_q + 1;
            max_q    = '0;
            sum_q    = '0;
            loaded_q = '0;
        end
    endtask

    task automatic add_bin(int unsigned mag, bit last);
        t_in_item it;
        it.magnitude = MAG_W'(mag);
        it.last_bin  = last;
        bins_to_send.push_back(it);
    endtask

    // Driver: holds a stalled request, idles in short bursts while busy.
    always @(posedge i_clk) begin : drive
        logic     nxt_valid;
        t_in_item nxt_item;
        nxt_valid = 1'b0;
        nxt_item  = in_item;
        if (!i_rst_n) begin
            send_gap = 0;
        end else if (in_valid && o_in_stall) begin
            nxt_valid = 1'b1;
        end else begin
            if (in_valid) begin
                absorb_bin(in_item);
            end
            if (send_gap > 0) begin
                send_gap--;
            end else if (bins_to_send.size() > 0) begin
                if (bins_to_send.size() > CALM_LEFT && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 4);
                end else begin
                    nxt_valid = 1'b1;
                    nxt_item  = bins_to_send.pop_front();
                end
            end
        end
        in_valid <= nxt_valid;
        in_item  <= nxt_item;
    end

    // Monitor: checks each accepted color and stalls the output in bursts.
    always @(posedge i_clk) begin : watch
        t_out_item want;
        logic      nxt_stall;
        nxt_stall = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (colors_due.size() == 0) begin
                    flag_error($sformatf("unexpected color: bin %0d col %0d rgb %h%h%h",
                        o_out_item.bin_index, o_out_item.column, o_out_item.red,
                        o_out_item.green, o_out_item.blue));
                end else begin
                    want = colors_due.pop_front();
                    if (want.red !== o_out_item.red || want.green !== o_out_item.green ||
                        want.blue !== o_out_item.blue ||
                        want.bin_index !== o_out_item.bin_index ||
                        want.column !== o_out_item.column ||
                        want.final_res !== o_out_item.final_res) begin
                        // Fields shown as rgb/bin/column/final.
                        flag_error($sformatf(
                            "mismatch: want %h%h%h/%0d/%0d/%b got %h%h%h/%0d/%0d/%b",
                            want.red, want.green, want.blue, want.bin_index, want.column,
                            want.final_res, o_out_item.red, o_out_item.green,
                            o_out_item.blue, o_out_item.bin_index, o_out_item.column,
                            o_out_item.final_res));
                    end
                end
            end
            if (hold_gap > 0) begin
                hold_gap--;
                nxt_stall = 1'b1;
            end else if (bins_to_send.size() > CALM_LEFT && $urandom_range(0, 7) == 0) begin
                hold_gap  = $urandom_range(0, 4);
                nxt_stall = 1'b1;
            end
        end
        out_stall <= nxt_stall;
    end

    // Cycles without any accepted request on either side.
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int          random_sent;
        int          frame_no;
        int          len;
        int unsigned scale;
        int unsigned mag;
        bit          end_mark;

        ramp(0, 30, 24'h000000, 24'h0e1116);
        ramp(30, 70, 24'h0e1116, 24'h506499);
        ramp(70, 110, 24'h506499, 24'h5ab464);
        ramp(110, 145, 24'h5ab464, 24'he0e02c);
        ramp(145, 200, 24'he0e02c, 24'hff3c1e);
        palette[200] = 24'hff3c1e;

        peak_q   = 16'hffff;
        max_q    = '0;
        sum_q    = '0;
        loaded_q = '0;
        column_q = 0;

        // Silent single-bin frames halve the peak down to its floor of one.
        for (int f = 0; f < 16; f++) begin
            add_bin(0, 1'b1);
        end
        // A full-scale pair drives the mean term past the saturation limit.
        add_bin(65535, 1'b0);
        add_bin(65535, 1'b1);
        // Mixed extremes, then a lone small bin against a decaying peak.
        add_bin(0, 1'b0);
        add_bin(65535, 1'b0);
        add_bin(32768, 1'b1);
        add_bin(1, 1'b1);

        // Random frames: mostly short, one that fills a whole store bank.
        random_sent = 0;
        frame_no    = 0;
        while (random_sent < RANDOM_ITEMS) begin
            end_mark = 1'b1;
            if (frame_no == 9) begin
                len      = MAX_BINS;
                end_mark = $urandom_range(0, 1);
            end else if ($urandom_range(0, 5) == 0) begin
                len = $urandom_range(9, 20);
            end else begin
                len = $urandom_range(1, 8);
            end
            case ($urandom_range(0, 3))
                0: scale = 65535;
                1: scale = 4095;
                2: scale = 255;
                default: scale = 7;
            endcase
            for (int i = 0; i < len; i++) begin
                mag = ($urandom_range(0, 5) == 0) ? scale : $urandom_range(0, scale);
                add_bin(mag, (i == len - 1) ? end_mark : 1'b0);
            end
            random_sent += len;
            frame_no++;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all requests out, all colors back, then a quiet tail.
        while (bins_to_send.size() != 0 || in_valid) begin
            @(posedge i_clk);
        end
        while (colors_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (colors_due.size() != 0) begin
            flag_error("colors still outstanding at end of run");
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/sfc_pkg.sv
hw/rtl/sfc_front.sv
hw/rtl/sfc_queue.sv
hw/rtl/sfc_back.sv
hw/rtl/spectrum_frame_colorizer_top.sv
tb/spectrum_frame_colorizer_top_tb.sv
